/* hdl/mrs_pkg.sv */
`timescale 1ns / 1ps
// shared constants, command type and crc-16 step for the modbus rtu register slave
// no dependencies

package mrs_pkg;

    localparam int REG_COUNT      = 16;
    localparam int FRAME_CAPACITY = 64;
    localparam int REG_AW         = $clog2(REG_COUNT);
    localparam int START_W        = $clog2(REG_COUNT + 1);
    localparam int FRAME_AW       = $clog2(FRAME_CAPACITY);
    localparam int LEN_W          = 7;
    localparam int MIN_FRAME      = 8;
    localparam int CMD_REGISTER   = 15;

    localparam logic [1:0] FUNC_RX_BYTE   = 2'd0;
    localparam logic [1:0] FUNC_LINE_IDLE = 2'd1;
    localparam logic [1:0] FUNC_LOCAL_WR  = 2'd2;

    localparam logic [7:0] MB_READ_REGS = 8'h03;
    localparam logic [7:0] MB_WRITE_REG = 8'h06;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] CMD_TABLE_WR = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_ECHO     = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         dev;
        logic [START_W-1:0] start;
        logic [15:0]        arg;
        logic [LEN_W-1:0]   len;
    } t_cmd;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/mrs_front.sv */
`timescale 1ns / 1ps
// front end: frame store, running crc check, frame classification
// depends on mrs_pkg

module mrs_front import mrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_func,
    input  logic [7:0]          i_rx_byte,
    input  logic [3:0]          i_reg_index,
    input  logic [15:0]         i_reg_value,
    input  logic [7:0]          i_dev_addr,
    input  logic                i_fifo_full,
    input  logic                i_echo_done,
    input  logic                i_rd_en,
    input  logic [FRAME_AW-1:0] i_rd_addr,
    output logic [7:0]          o_mem_q,
    output logic                o_busy,
    output logic                o_push,
    output t_cmd                o_push_cmd
);

    logic [7:0]       r_mem [FRAME_CAPACITY];
    logic [7:0]       r_mem_q;
    logic [LEN_W-1:0] r_len;
    logic [15:0]      r_crc;
    logic [7:0]       r_p1, r_p2;
    logic [7:0]       r_b0, r_b1, r_b2, r_b3, r_b4, r_b5;
    logic             r_echo_hold;

    logic        store, frame_end, good;
    logic [15:0] reg_addr, reg_arg;
    logic [16:0] range_end;
    t_cmd        cmd;

    assign store     = i_accept && (i_func == FUNC_RX_BYTE) &&
                       (r_len < LEN_W'(FRAME_CAPACITY));
    assign frame_end = i_accept && (i_func == FUNC_LINE_IDLE);
    assign reg_addr  = {r_b2, r_b3};
    assign reg_arg   = {r_b4, r_b5};
    assign range_end = {1'b0, reg_addr} + {1'b0, reg_arg};
    assign good      = (r_len >= LEN_W'(MIN_FRAME)) && (r_b0 == i_dev_addr) &&
                       (r_crc == {r_p1, r_p2});

    always_comb begin
        cmd       = '0;
        cmd.dev   = r_b0;
        cmd.arg   = reg_arg;
        cmd.len   = r_len;
        cmd.start = reg_addr[START_W-1:0];
        o_push    = 1'b0;
        if (i_accept && (i_func == FUNC_LOCAL_WR)) begin
            cmd.kind  = CMD_TABLE_WR;
            cmd.start = START_W'(i_reg_index);
            cmd.arg   = i_reg_value;
            o_push    = 1'b1;
        end else if (frame_end && good) begin
            if ((r_b1 == MB_READ_REGS) && (range_end <= 17'(REG_COUNT))) begin
                cmd.kind = CMD_READ;
                o_push   = 1'b1;
            end else if ((r_b1 == MB_WRITE_REG) && (reg_addr == 16'(CMD_REGISTER))) begin
                cmd.kind = CMD_ECHO;
                o_push   = 1'b1;
            end
        end
    end

    assign o_push_cmd = cmd;
    assign o_busy     = i_fifo_full || r_echo_hold;
    assign o_mem_q    = r_mem_q;

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_len[FRAME_AW-1:0]] <= i_rx_byte;
        end
        if (i_rd_en) begin
            r_mem_q <= r_mem[i_rd_addr];
        end
    end

    // crc runs two bytes behind so the trailing checksum stays out of it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_crc       <= CRC_INIT;
            r_echo_hold <= 1'b0;
        end else begin
            if (frame_end) begin
                r_len <= '0;
                r_crc <= CRC_INIT;
            end else if (store) begin
                r_len <= r_len + 1'b1;
                if (r_len >= LEN_W'(2)) begin
                    r_crc <= crc16_byte(r_crc, r_p2);
                end
            end
            if (o_push && (cmd.kind == CMD_ECHO)) begin
                r_echo_hold <= 1'b1;
            end else if (i_echo_done) begin
                r_echo_hold <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_p1 <= i_rx_byte;
            r_p2 <= r_p1;
            if (r_len == LEN_W'(0)) r_b0 <= i_rx_byte;
            if (r_len == LEN_W'(1)) r_b1 <= i_rx_byte;
            if (r_len == LEN_W'(2)) r_b2 <= i_rx_byte;
            if (r_len == LEN_W'(3)) r_b3 <= i_rx_byte;
            if (r_len == LEN_W'(4)) r_b4 <= i_rx_byte;
            if (r_len == LEN_W'(5)) r_b5 <= i_rx_byte;
        end
    end

endmodule

/* hdl/mrs_cmd_fifo.sv */
`timescale 1ns / 1ps
// two-entry command queue between front and back
// depends on mrs_pkg

module mrs_cmd_fifo import mrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_cmd   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* hdl/mrs_back.sv */
`timescale 1ns / 1ps
// back end: register table, pin controls and response byte sequencer
// depends on mrs_pkg

module mrs_back import mrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_empty,
    input  logic [7:0]          i_mem_q,
    output logic                o_pop,
    output logic                o_rd_en,
    output logic [FRAME_AW-1:0] o_rd_addr,
    output logic                o_echo_done,
    output logic                o_valid,
    output logic [7:0]          o_tx_byte,
    output logic                o_last_byte,
    output logic [3:0]          o_control_bits
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_ADDR = 4'd1;
    localparam logic [3:0] ST_RD_FUNC = 4'd2;
    localparam logic [3:0] ST_RD_CNT  = 4'd3;
    localparam logic [3:0] ST_RD_HI   = 4'd4;
    localparam logic [3:0] ST_RD_LO   = 4'd5;
    localparam logic [3:0] ST_CRC_LO  = 4'd6;
    localparam logic [3:0] ST_CRC_HI  = 4'd7;
    localparam logic [3:0] ST_ECHO    = 4'd8;

    logic [15:0]        r_tbl [REG_COUNT];
    logic [3:0]         r_pins;
    logic [3:0]         r_state;
    logic [7:0]         r_dev;
    logic [REG_AW-1:0]  r_ptr;
    logic [START_W-1:0] r_left;
    logic [15:0]        r_crc;
    logic [LEN_W-1:0]   r_ecnt, r_elen;
    logic               r_mv, r_ml;
    logic               r_valid, r_last;
    logic [7:0]         r_tx;

    logic        emit, emit_last, upd_crc;
    logic [7:0]  b;
    logic [15:0] cur;

    assign cur = r_tbl[r_ptr];

    always_comb begin
        emit      = 1'b1;
        emit_last = 1'b0;
        upd_crc   = 1'b1;
        b         = 8'h00;
        case (r_state)
            ST_RD_ADDR: b = r_dev;
            ST_RD_FUNC: b = MB_READ_REGS;
            ST_RD_CNT:  b = {{(7-START_W){1'b0}}, r_left, 1'b0};
            ST_RD_HI:   b = cur[15:8];
            ST_RD_LO:   b = cur[7:0];
            ST_CRC_LO: begin
                b       = r_crc[7:0];
                upd_crc = 1'b0;
            end
            ST_CRC_HI: begin
                b         = r_crc[15:8];
                upd_crc   = 1'b0;
                emit_last = 1'b1;
            end
            default: begin
                emit    = 1'b0;
                upd_crc = 1'b0;
            end
        endcase
    end

    assign o_pop       = (r_state == ST_IDLE) && !i_empty;
    assign o_rd_en     = (r_state == ST_ECHO);
    assign o_rd_addr   = r_ecnt[FRAME_AW-1:0];
    assign o_echo_done = r_mv && r_ml;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pins  <= '0;
            r_mv    <= 1'b0;
            r_valid <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) begin
                r_tbl[k] <= '0;
            end
        end else begin
            r_mv    <= o_rd_en;
            r_valid <= emit || r_mv;
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            CMD_TABLE_WR: r_tbl[i_cmd.start[REG_AW-1:0]] <= i_cmd.arg;
                            CMD_READ:     r_state <= ST_RD_ADDR;
                            CMD_ECHO: begin
                                r_tbl[CMD_REGISTER] <= i_cmd.arg;
                                r_pins  <= {~i_cmd.arg[3], i_cmd.arg[2:0]};
                                r_state <= ST_ECHO;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD_ADDR: r_state <= ST_RD_FUNC;
                ST_RD_FUNC: r_state <= ST_RD_CNT;
                ST_RD_CNT:  r_state <= (r_left == '0) ? ST_CRC_LO : ST_RD_HI;
                ST_RD_HI:   r_state <= ST_RD_LO;
                ST_RD_LO:   r_state <= (r_left == START_W'(1)) ? ST_CRC_LO : ST_RD_HI;
                ST_CRC_LO:  r_state <= ST_CRC_HI;
                ST_CRC_HI:  r_state <= ST_IDLE;
                ST_ECHO: begin
                    if (r_ecnt == r_elen - 1'b1) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dev  <= i_cmd.dev;
            r_ptr  <= i_cmd.start[REG_AW-1:0];
            r_left <= i_cmd.arg[START_W-1:0];
            r_crc  <= CRC_INIT;
            r_ecnt <= '0;
            r_elen <= i_cmd.len;
        end else begin
            if (upd_crc) r_crc <= crc16_byte(r_crc, b);
            if (r_state == ST_RD_LO) begin
                r_ptr  <= r_ptr + 1'b1;
                r_left <= r_left - 1'b1;
            end
            if (o_rd_en) r_ecnt <= r_ecnt + 1'b1;
        end
        r_ml <= (r_ecnt == r_elen - 1'b1);
        if (r_mv) begin
            r_tx   <= i_mem_q;
            r_last <= r_ml;
        end else begin
            r_tx   <= b;
            r_last <= emit_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_tx_byte      = r_tx;
    assign o_last_byte    = r_last;
    assign o_control_bits = r_pins;

endmodule

/* hdl/modbus_rtu_register_slave_unit.sv */
`timescale 1ns / 1ps
// top level of the modbus rtu register slave: apb register, front, queue, back
// depends on mrs_pkg, mrs_front, mrs_cmd_fifo, mrs_back

// Each item (received byte, line idle, local table write) is taken when start
// is high and busy is low. A line-idle item on a valid frame queues a command;
// the back end then sends the response one byte per cycle on o_tx_valid, which
// cannot be held off: a read of n registers gives 5+2n bytes, an echo gives the
// frame's length in bytes through the registered frame store read. Busy is high
// while the two-entry command queue is full and from a write-echo frame end
// until its last byte goes out, since the echo reads the frame store.
module modbus_rtu_register_slave_unit import mrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item transfer
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [3:0]  i_reg_index,
    input  logic [15:0] i_reg_value,
    // response transfer
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic [3:0]  o_control_bits,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]          r_dev_addr;
    logic                accept;
    logic                fifo_full, fifo_empty, push, pop, echo_done, rd_en;
    logic [FRAME_AW-1:0] rd_addr;
    logic [7:0]          mem_q;
    t_cmd                push_cmd, pop_cmd;

    // device address register at byte address zero
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'h0, r_dev_addr} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 8'd1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_dev_addr <= pwdata[7:0];
        end
    end

    assign accept = start && !busy;

    mrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_rx_byte   (i_rx_byte),
        .i_reg_index (i_reg_index),
        .i_reg_value (i_reg_value),
        .i_dev_addr  (r_dev_addr),
        .i_fifo_full (fifo_full),
        .i_echo_done (echo_done),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_mem_q     (mem_q),
        .o_busy      (busy),
        .o_push      (push),
        .o_push_cmd  (push_cmd)
    );

    mrs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    mrs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (pop_cmd),
        .i_empty        (fifo_empty),
        .i_mem_q        (mem_q),
        .o_pop          (pop),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .o_echo_done    (echo_done),
        .o_valid        (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_last_byte    (o_last_byte),
        .o_control_bits (o_control_bits)
    );

    // queue never takes a command while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_full)
        else $error("command pushed into full queue");

    // queue never popped while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_empty)
        else $error("command popped from empty queue");

    // frame store is not refilled while an echo reads it
    a_echo_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !accept)
        else $error("item accepted during echo read");

    // last byte only on a strobed response byte
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte |-> o_tx_valid)
        else $error("last byte without strobe");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for modbus_rtu_register_slave_unit
// depends on mrs_pkg and the unit's rtl; an internal scoreboard predicts every response byte

module tb;
    import mrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RANDOM_ITEMS   = 410;

    typedef bit [7:0] t_bytes[$];

    typedef struct {
        bit [7:0] tx;
        bit       last;
        bit [3:0] ctrl;
    } t_tx_byte;

    // response predictor with its own copy of the slave's state
    class slave_scoreboard;
        bit [7:0]  dev_addr;
        bit [7:0]  frame_buf[FRAME_CAPACITY];
        int        frame_len;
        bit [15:0] reg_table[REG_COUNT];
        bit [3:0]  pin_bits;
        t_tx_byte  pending_tx[$];
        int        errors;
        int        bytes_seen;
        int        replies;

        function new();
            dev_addr  = 8'd1;
            frame_len = 0;
            pin_bits  = 4'd0;
            foreach (reg_table[k]) reg_table[k] = 16'd0;
            errors     = 0;
            bytes_seen = 0;
            replies    = 0;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        function bit [15:0] crc_of(t_bytes q);
            bit [15:0] c;
            c = 16'hFFFF;
            foreach (q[k]) begin
                c ^= {8'h00, q[k]};
                repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            end
            return c;
        endfunction

        function void queue_reply(t_bytes q);
            t_tx_byte e;
            foreach (q[k]) begin
                e.tx   = q[k];
                e.last = (k == q.size() - 1);
                e.ctrl = pin_bits;
                pending_tx.push_back(e);
            end
            replies++;
        endfunction

        function void close_frame();
            int        n;
            bit [15:0] addr, arg, crc;
            t_bytes    msg;
            n = frame_len;
            frame_len = 0;
            if (n < MIN_FRAME || frame_buf[0] != dev_addr) return;
            msg = {};
            for (int k = 0; k < n - 2; k++) msg.push_back(frame_buf[k]);
            if (crc_of(msg) != {frame_buf[n-1], frame_buf[n-2]}) return;
            addr = {frame_buf[2], frame_buf[3]};
            arg  = {frame_buf[4], frame_buf[5]};
            if (frame_buf[1] == MB_READ_REGS) begin
                if (int'(addr) + int'(arg) > REG_COUNT) return;
                msg = {dev_addr, MB_READ_REGS, 8'(arg * 2)};
                for (int k = 0; k < arg; k++) begin
                    msg.push_back(reg_table[addr+k][15:8]);
                    msg.push_back(reg_table[addr+k][7:0]);
                end
                crc = crc_of(msg);
                msg.push_back(crc[7:0]);
                msg.push_back(crc[15:8]);
                queue_reply(msg);
            end else if (frame_buf[1] == MB_WRITE_REG && addr == CMD_REGISTER) begin
                reg_table[CMD_REGISTER] = arg;
                pin_bits = {~arg[3], arg[2:0]};
                msg = {};
                for (int k = 0; k < n; k++) msg.push_back(frame_buf[k]);
                queue_reply(msg);
            end
        endfunction

        // called for every accepted item transfer
        function void note_item(bit [1:0] f, bit [7:0] rx, bit [3:0] idx, bit [15:0] v);
            case (f)
                FUNC_RX_BYTE: begin
                    if (frame_len < FRAME_CAPACITY) begin
                        frame_buf[frame_len] = rx;
                        frame_len++;
                    end
                end
                FUNC_LINE_IDLE: close_frame();
                FUNC_LOCAL_WR: reg_table[idx] = v;
                default: ;
            endcase
        endfunction

        task check_result(bit [7:0] tx, bit last, bit [3:0] ctrl);
            t_tx_byte e;
            bytes_seen++;
            if (pending_tx.size() == 0) begin
                report($sformatf("unexpected response byte %02h", tx));
                return;
            end
            e = pending_tx.pop_front();
            if (tx != e.tx)
                report($sformatf("tx_byte %02h, want %02h", tx, e.tx));
            if (last != e.last)
                report($sformatf("last_byte %0d, want %0d", last, e.last));
            if (ctrl != e.ctrl)
                report($sformatf("control_bits %h, want %h", ctrl, e.ctrl));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [7:0]  i_rx_byte;
    logic [3:0]  i_reg_index;
    logic [15:0] i_reg_value;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_last_byte;
    logic [3:0]  o_control_bits;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slave_scoreboard sb;
    int  items_sent;
    int  frames_sent;
    int  quiet_cycles;
    bit  steady_run;   // long stretch with no sender gaps

    modbus_rtu_register_slave_unit DUT (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_rx_byte, .i_reg_index, .i_reg_value,
        .o_tx_valid, .o_tx_byte, .o_last_byte, .o_control_bits,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // response bytes cannot be held off, so every strobe is a transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_tx_valid) begin
            sb.check_result(o_tx_byte, o_last_byte, o_control_bits);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_tx_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one item transfer; entered and left at a falling edge
    task automatic send_item(bit [1:0] f, bit [7:0] rx, bit [3:0] idx, bit [15:0] v);
        if (!steady_run && $urandom_range(99) < 20) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start       = 1'b1;
        i_func      = f;
        i_rx_byte   = rx;
        i_reg_index = idx;
        i_reg_value = v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(f, rx, idx, v);
        items_sent++;
        @(negedge i_clk);
    endtask

    // bytes on the line, then the idle marker; unused fields carry noise
    task automatic send_frame(t_bytes q);
        foreach (q[k]) send_item(FUNC_RX_BYTE, q[k], 4'($urandom), 16'($urandom));
        send_item(FUNC_LINE_IDLE, 8'($urandom), 4'($urandom), 16'($urandom));
        frames_sent++;
    endtask

    function automatic t_bytes make_frame(bit [7:0] dev, bit [7:0] fc, bit [15:0] addr,
                                          bit [15:0] arg, int pad);
        t_bytes    q;
        bit [15:0] crc;
        q = {dev, fc, addr[15:8], addr[7:0], arg[15:8], arg[7:0]};
        repeat (pad) q.push_back(8'($urandom));
        crc = sb.crc_of(q);
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
        return q;
    endfunction

    // hold the sender until the response queue is empty and the block has settled
    task automatic drain();
        start = 1'b0;
        while (sb.pending_tx.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_device_address(bit [7:0] a);
        drain();
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = 3'd0;
        pwdata  = {24'($urandom), a};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.dev_addr = a;
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[7:0] != a)
            sb.report($sformatf("device_address reads %02h, want %02h", prdata[7:0], a));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // mostly well-formed requests, some broken frames and noise
    task automatic random_request();
        int        pick, n, lo;
        bit [7:0]  dev;
        bit [15:0] addr, arg;
        t_bytes    q;
        pick = $urandom_range(99);
        dev  = ($urandom_range(9) == 0) ? 8'($urandom) : sb.dev_addr;
        if (pick < 45) begin
            // register range read, occasionally out of bounds
            lo   = $urandom_range(REG_COUNT);
            addr = 16'(lo);
            arg  = 16'($urandom_range(REG_COUNT - lo));
            if ($urandom_range(9) == 0) arg = 16'($urandom_range(REG_COUNT - lo + 1, 20));
            if ($urandom_range(29) == 0) begin
                addr = 16'($urandom);
                arg  = 16'($urandom);
            end
            q = make_frame(dev, MB_READ_REGS, addr, arg, ($urandom_range(7) == 0) ? 2 : 0);
            if ($urandom_range(14) == 0) q[$urandom_range(q.size() - 1)] ^= 8'h10;
            send_frame(q);
        end else if (pick < 65) begin
            // command word write, sometimes padded or aimed at another register
            addr = ($urandom_range(4) == 0) ? 16'($urandom_range(14)) : 16'(CMD_REGISTER);
            n    = ($urandom_range(5) == 0) ? $urandom_range(1, 10) : 0;
            if ($urandom_range(24) == 0) n = FRAME_CAPACITY - 8;
            q = make_frame(dev, MB_WRITE_REG, addr, 16'($urandom), n);
            if (n == FRAME_CAPACITY - 8)
                repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
            send_frame(q);
        end else if (pick < 80) begin
            send_item(FUNC_LOCAL_WR, 8'($urandom), 4'($urandom), 16'($urandom));
        end else if (pick < 87) begin
            // unsupported function code with a good checksum
            q = make_frame(dev, 8'($urandom_range(7, 255)), 16'(CMD_REGISTER),
                           16'($urandom), 0);
            send_frame(q);
        end else if (pick < 95) begin
            // line noise: short or random frames
            q = {};
            repeat ($urandom_range(0, 12)) q.push_back(8'($urandom));
            send_frame(q);
        end else begin
            send_item(2'd3, 8'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        bit [7:0] phase_addr[4];
        sb          = new();
        items_sent  = 0;
        frames_sent = 0;
        steady_run  = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = FUNC_RX_BYTE;
        i_rx_byte   = 8'd0;
        i_reg_index = 4'd0;
        i_reg_value = 16'd0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 3'd0;
        pwdata      = 32'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: table extremes, full read, command echo with both fault levels
        send_item(FUNC_LOCAL_WR, 8'h00, 4'd0, 16'hFFFF);
        send_item(FUNC_LOCAL_WR, 8'hFF, 4'd15, 16'h0000);
        send_frame(make_frame(8'd1, MB_READ_REGS, 16'd0, 16'(REG_COUNT), 0));
        send_frame(make_frame(8'd1, MB_WRITE_REG, 16'(CMD_REGISTER), 16'h0007, 0));
        drain();
        send_frame(make_frame(8'd1, MB_WRITE_REG, 16'(CMD_REGISTER), 16'hFFF8, 0));

        phase_addr = '{8'd0, 8'd255, 8'($urandom), 8'd1};
        for (int p = 0; p < 4; p++) begin
            set_device_address(phase_addr[p]);
            steady_run = (p == 1);
            while (items_sent < ((p + 1) * RANDOM_ITEMS) / 4) random_request();
        end
        steady_run = 1'b0;

        drain();
        $display("covered %0d item transfers in %0d frames, %0d replies, %0d response bytes",
                 items_sent, frames_sent, sb.replies, sb.bytes_seen);
        $display("four device addresses including 0 and 255");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/mrs_pkg.sv
hdl/mrs_front.sv
hdl/mrs_cmd_fifo.sv
hdl/mrs_back.sv
hdl/modbus_rtu_register_slave_unit.sv
tb/tb.sv
